FILE: hw/rtl/ghash_pkg.sv
// GHASH accumulator package: widths, register index codes, FSM encoding
// and the one-bit GF(2^128) multiply step used by the digit-serial multiplier.
// No dependencies.
`default_nettype none

package ghash_pkg;

   localparam int HalfW      = 64;
   localparam int BlockW     = 2 * HalfW;
   localparam int BlockBytes = 16;
   localparam int CountW     = 5;
   localparam int DigitW     = 8;
   localparam int DigitCount = BlockW / DigitW;
   localparam int DigitIdxW  = $clog2(DigitCount);
   localparam int CsrIndexW  = 2;

   // reduction constant, reflected bit order
   localparam logic [BlockW-1:0] GhashR = {8'hE1, {(BlockW - 8){1'b0}}};

   typedef enum logic [CsrIndexW-1:0] {
      CSR_KEY_HIGH   = 2'd0,
      CSR_KEY_LOW    = 2'd1,
      CSR_START_HIGH = 2'd2,
      CSR_START_LOW  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BUSY = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   typedef struct packed {
      logic [BlockW-1:0] r;
      logic [BlockW-1:0] v;
   } mul_pair_type;

   // one iteration: conditional accumulate, then V = V * x mod P
   function automatic mul_pair_type ghash_bit_step(mul_pair_type cur, logic b);
      mul_pair_type nxt;
      nxt.r = b ? (cur.r ^ cur.v) : cur.r;
      nxt.v = {1'b0, cur.v[BlockW-1:1]};
      if (cur.v[0]) begin
         nxt.v = nxt.v ^ GhashR;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ghash_csr.sv
// GHASH configuration registers: hash key and start value.
// Depends on ghash_pkg.
`default_nettype none

module ghash_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ghash_pkg::CsrIndexW-1:0] csr_index,
   input  logic [ghash_pkg::HalfW-1:0]     csr_wdata,
   output logic [ghash_pkg::BlockW-1:0]    key,
   output logic [ghash_pkg::BlockW-1:0]    start
);
   import ghash_pkg::*;

   logic [HalfW-1:0] key_high_ff, key_low_ff, start_high_ff, start_low_ff;
   csr_index_type    idx;

   assign idx = csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         start_high_ff <= '0;
         start_low_ff  <= '0;
      end else if (csr_we) begin
         unique case (idx)
            CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
            CSR_KEY_LOW:    key_low_ff    <= csr_wdata;
            CSR_START_HIGH: start_high_ff <= csr_wdata;
            CSR_START_LOW:  start_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign key   = {key_high_ff, key_low_ff};
   assign start = {start_high_ff, start_low_ff};

endmodule

`default_nettype wire

FILE: hw/rtl/ghash_mul.sv
// Digit-serial GF(2^128) multiplier, 8 bits of X per cycle.
// Depends on ghash_pkg (bit step function, constants).
`default_nettype none

module ghash_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ghash_pkg::BlockW-1:0] x,
   input  logic [ghash_pkg::BlockW-1:0] h,
   output logic                         done,
   output logic [ghash_pkg::BlockW-1:0] z
);
   import ghash_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DigitIdxW-1:0] digit_ff, digit_in;
   logic [BlockW-1:0]    x_ff, x_in;
   mul_pair_type         acc_ff, acc_in;
   mul_pair_type         stage [DigitW+1];

   // eight chained bit steps, X taken MSB first
   always_comb begin
      stage[0] = acc_ff;
      for (int k = 0; k < DigitW; k++) begin
         stage[k+1] = ghash_bit_step(stage[k], x_ff[BlockW-1-k]);
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      digit_in = digit_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         digit_in = '0;
         x_in     = x;
         acc_in.r = '0;
         acc_in.v = h;
      end else if (busy_ff) begin
         acc_in   = stage[DigitW];
         x_in     = {x_ff[BlockW-DigitW-1:0], {DigitW{1'b0}}};
         digit_in = digit_ff + 1'b1;
         if (digit_ff == DigitIdxW'(DigitCount - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         digit_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         digit_ff <= digit_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign z    = acc_ff.r;

endmodule

`default_nettype wire

FILE: hw/rtl/ghash_accumulator_core.sv
// GHASH accumulator top level. An item with a nonzero byte count occupies the core through
// the digit-serial multiply (one 8-bit digit per cycle) and a writeback of the product.
// An item with zero byte count needs no multiply. A last item then passes through ST_HOLD,
// which moves the accumulator into the result register and raises rsp_valid once the result
// slot is free. Synchronous active-high reset clears key, start, accumulator, control.
// Depends on ghash_pkg, ghash_csr, ghash_mul.
`default_nettype none

module ghash_accumulator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ghash_pkg::CsrIndexW-1:0] csr_index,
   input  logic [ghash_pkg::HalfW-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ghash_pkg::HalfW-1:0]     req_block_high,
   input  logic [ghash_pkg::HalfW-1:0]     req_block_low,
   input  logic [ghash_pkg::CountW-1:0]    req_byte_count,
   input  logic                            req_first_block,
   input  logic                            req_last_block,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ghash_pkg::HalfW-1:0]     rsp_hash_high,
   output logic [ghash_pkg::HalfW-1:0]     rsp_hash_low
);
   import ghash_pkg::*;

   state_type         state_ff, state_in;
   logic [BlockW-1:0] acc_ff, acc_in;
   logic [BlockW-1:0] hash_ff, hash_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_ff, last_in;
   logic [BlockW-1:0] key, start;
   logic [BlockW-1:0] req_block;
   logic [BlockW-1:0] acc_base, data_masked, operand;
   logic              req_beat, mul_start, mul_done;
   logic [BlockW-1:0] mul_z;

   ghash_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key       (key),
      .start     (start)
   );

   ghash_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (operand),
      .h     (key),
      .done  (mul_done),
      .z     (mul_z)
   );

   assign req_block = {req_block_high, req_block_low};

   // bytes at or past the count read as zero; counts above 16 keep all bytes
   always_comb begin
      for (int j = 0; j < BlockBytes; j++) begin
         data_masked[BlockW-1-8*j -: 8] =
            (CountW'(j) < req_byte_count) ? req_block[BlockW-1-8*j -: 8] : 8'h00;
      end
   end

   assign acc_base  = req_first_block ? start : acc_ff;
   assign operand   = acc_base ^ data_masked;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign mul_start = req_beat && (req_byte_count != '0);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               acc_in  = acc_base;
               last_in = req_last_block;
               if (req_byte_count != '0) begin
                  state_in = ST_BUSY;
               end else if (req_last_block) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_BUSY: begin
            if (mul_done) begin
               acc_in   = mul_z;
               state_in = last_ff ? ST_HOLD : ST_IDLE;
            end
         end
         ST_HOLD: begin
            // wait until the result slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               hash_in      = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
      hash_ff <= hash_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hash_high = hash_ff[BlockW-1:HalfW];
   assign rsp_hash_low  = hash_ff[HalfW-1:0];

   a_done_in_busy: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_BUSY))
      else $error("multiplier finished outside busy state");

   a_hold_acc_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |=> $stable(acc_ff))
      else $error("accumulator changed while result pending");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_HOLD))
      else $error("result raised without hold state");

endmodule

`default_nettype wire
